### rtl/core/emfd_pkg.sv
package emfd_pkg;

    localparam int FRAME_LENGTH       = 24;
    localparam int GAIN_FRACTION_BITS = 16;
    localparam int ENERGY_WIDTH       = 48;

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 24;
    localparam int GAIN_W     = 20;
    localparam int SCALED_W   = 36;
    localparam int TOTAL_W    = 48;
    localparam int PRODUCT_W  = COUNT_W + GAIN_W;
    localparam int GAIN_SHIFT = GAIN_FRACTION_BITS - 8;
    localparam int POS_W      = $clog2(FRAME_LENGTH);

    localparam int PAYLOAD_DEPTH     = 13;
    localparam int SLOT_W            = $clog2(PAYLOAD_DEPTH);
    localparam int FIRST_PAYLOAD_POS = 2;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h5A;

    localparam int CFG_INDEX_W = 2;

    localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RESET = 20'd34859;
    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RESET = 20'd91022;
    localparam logic [GAIN_W-1:0] POWER_GAIN_RESET   = 20'd65536;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SECOND  = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VOLTAGE_GAIN = 2'd0,
        CFG_CURRENT_GAIN = 2'd1,
        CFG_POWER_GAIN   = 2'd2
    } cfg_reg_t;

    // one decoded frame; counts are zero when the checksum fails
    typedef struct packed {
        logic                valid;
        logic                ok;
        logic [COUNT_W-1:0]  voltage;
        logic [COUNT_W-1:0]  current;
        logic [COUNT_W-1:0]  power;
        logic [COUNT_W-1:0]  energy;
        logic [BYTE_W-1:0]   pf;
    } frame_t;

endpackage

### rtl/core/energy_meter_frame_decoder.sv
// The edge that accepts a frame's last byte loads stage A; stage B and the output register follow.
// Throughput: one byte per cycle while in_ready is high; every byte of a frame is taken back to
// back, and the three stages (decode, multiply, accumulate) each hold one frame.
// Input stalls only when all three stages are full and the result is not taken.
// Reset (rst_n, async, active low) clears the framing state, the energy sum and the
// pipeline valids, and loads the gain registers with their default coefficients.
module energy_meter_frame_decoder
    import emfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   frame_ok,
    output logic [COUNT_W-1:0]     voltage_count,
    output logic [COUNT_W-1:0]     current_count,
    output logic [COUNT_W-1:0]     power_count,
    output logic [COUNT_W-1:0]     energy_count,
    output logic [BYTE_W-1:0]      power_factor_hundredths,
    output logic [SCALED_W-1:0]    voltage_scaled,
    output logic [SCALED_W-1:0]    current_scaled,
    output logic [SCALED_W-1:0]    power_scaled,
    output logic [TOTAL_W-1:0]     energy_total
);

    logic [GAIN_W-1:0]       voltage_gain_reg, current_gain_reg, power_gain_reg;

    logic                    take;
    logic                    a_en, b_en, c_en;
    frame_t                  frame;

    logic                    a_valid_reg;
    frame_t                  a_frame_reg;

    logic                    b_valid_reg;
    logic                    b_ok_reg;
    logic [COUNT_W-1:0]      b_voltage_reg, b_current_reg, b_power_reg, b_energy_reg;
    logic [BYTE_W-1:0]       b_pf_reg;
    logic [PRODUCT_W-1:0]    b_vprod_reg, b_iprod_reg, b_pprod_reg;

    logic [SCALED_W-1:0]     v_scaled, i_scaled, p_scaled;
    logic [ENERGY_WIDTH-1:0] energy_sum;
    logic [ENERGY_WIDTH-1:0] energy_acc_reg;

    logic                    out_valid_reg;
    logic                    frame_ok_reg;
    logic [COUNT_W-1:0]      voltage_count_reg, current_count_reg;
    logic [COUNT_W-1:0]      power_count_reg, energy_count_reg;
    logic [BYTE_W-1:0]       pf_reg;
    logic [SCALED_W-1:0]     voltage_scaled_reg, current_scaled_reg, power_scaled_reg;
    logic [TOTAL_W-1:0]      energy_total_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_gain_reg <= VOLTAGE_GAIN_RESET;
            current_gain_reg <= CURRENT_GAIN_RESET;
            power_gain_reg   <= POWER_GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VOLTAGE_GAIN: voltage_gain_reg <= cfg_data;
                CFG_CURRENT_GAIN: current_gain_reg <= cfg_data;
                CFG_POWER_GAIN:   power_gain_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // each stage moves when the one after it is empty or moving
    assign c_en     = !out_valid_reg || out_ready;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;
    assign take     = in_valid && a_en;

    emfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .frame   (frame)
    );

    // stage A: decoded frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_en)
        begin
            a_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_frame_reg <= frame;
        end
    end

    // stage B: gain products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en && a_valid_reg)
        begin
            b_ok_reg      <= a_frame_reg.ok;
            b_voltage_reg <= a_frame_reg.voltage;
            b_current_reg <= a_frame_reg.current;
            b_power_reg   <= a_frame_reg.power;
            b_energy_reg  <= a_frame_reg.energy;
            b_pf_reg      <= a_frame_reg.pf;
            b_vprod_reg   <= PRODUCT_W'(a_frame_reg.voltage) * PRODUCT_W'(voltage_gain_reg);
            b_iprod_reg   <= PRODUCT_W'(a_frame_reg.current) * PRODUCT_W'(current_gain_reg);
            b_pprod_reg   <= PRODUCT_W'(a_frame_reg.power) * PRODUCT_W'(power_gain_reg);
        end
    end

    // stage C: scale, accumulate, output register
    assign v_scaled   = SCALED_W'(b_vprod_reg >> GAIN_SHIFT);
    assign i_scaled   = SCALED_W'(b_iprod_reg >> GAIN_SHIFT);
    assign p_scaled   = SCALED_W'(b_pprod_reg >> GAIN_SHIFT);
    assign energy_sum = energy_acc_reg + ENERGY_WIDTH'(p_scaled);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            energy_acc_reg <= '0;
        end
        else if (c_en)
        begin
            out_valid_reg <= b_valid_reg;
            if (b_valid_reg && b_ok_reg)
            begin
                energy_acc_reg <= energy_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en && b_valid_reg)
        begin
            frame_ok_reg       <= b_ok_reg;
            voltage_count_reg  <= b_voltage_reg;
            current_count_reg  <= b_current_reg;
            power_count_reg    <= b_power_reg;
            energy_count_reg   <= b_energy_reg;
            pf_reg             <= b_pf_reg;
            voltage_scaled_reg <= v_scaled;
            current_scaled_reg <= i_scaled;
            power_scaled_reg   <= p_scaled;
            // a failed frame reports zero, not the running sum
            energy_total_reg   <= b_ok_reg ? TOTAL_W'(energy_sum) : '0;
        end
    end

    assign out_valid               = out_valid_reg;
    assign frame_ok                = frame_ok_reg;
    assign voltage_count           = voltage_count_reg;
    assign current_count           = current_count_reg;
    assign power_count             = power_count_reg;
    assign energy_count            = energy_count_reg;
    assign power_factor_hundredths = pf_reg;
    assign voltage_scaled          = voltage_scaled_reg;
    assign current_scaled          = current_scaled_reg;
    assign power_scaled            = power_scaled_reg;
    assign energy_total            = energy_total_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (a_valid_reg && b_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipeline stage");

    a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_ok) |-> (voltage_count == '0 && current_count == '0
            && power_count == '0 && energy_count == '0 && power_factor_hundredths == '0
            && voltage_scaled == '0 && current_scaled == '0 && power_scaled == '0
            && energy_total == '0))
        else $error("failed frame carries nonzero fields");

    a_acc_only_on_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !(c_en && b_valid_reg && b_ok_reg) |=> $stable(energy_acc_reg))
        else $error("energy sum changed without a good frame");

    a_total_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_ok) |-> (energy_total == TOTAL_W'(energy_acc_reg)))
        else $error("reported energy total differs from accumulator");
`endif

endmodule

### rtl/core/emfd_parser.sv
module emfd_parser
    import emfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] rx_byte,
    output frame_t            frame
);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]   payload_reg [PAYLOAD_DEPTH];
    logic [POS_W-1:0]    slot;
    logic                last_byte;
    logic                slot_wr;
    logic                checksum_ok;

    assign last_byte   = (pos_reg == POS_W'(FRAME_LENGTH - 1));
    assign slot        = pos_reg - POS_W'(FIRST_PAYLOAD_POS);
    assign slot_wr     = take && (phase_reg == PH_COLLECT) && !last_byte
                         && (slot < POS_W'(PAYLOAD_DEPTH));
    // frame is good when the last byte is the two's complement of the sum
    assign checksum_ok = ((~sum_reg + 8'd1) == rx_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            payload_reg[slot[SLOT_W-1:0]] <= rx_byte;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        frame      = '0;
        if (take)
        begin
            unique case (phase_reg)
                PH_SECOND:
                begin
                    // a wrong second byte is consumed, even another 0x55
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_COLLECT;
                        pos_next   = POS_W'(FIRST_PAYLOAD_POS);
                        sum_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_COLLECT:
                begin
                    if (!last_byte)
                    begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        phase_next  = PH_HUNT;
                        pos_next    = '0;
                        sum_next    = '0;
                        frame.valid = 1'b1;
                        frame.ok    = checksum_ok;
                        if (checksum_ok)
                        begin
                            frame.voltage = {payload_reg[0], payload_reg[1], payload_reg[2]};
                            frame.current = {payload_reg[3], payload_reg[4], payload_reg[5]};
                            frame.power   = {payload_reg[6], payload_reg[7], payload_reg[8]};
                            frame.energy  = {payload_reg[9], payload_reg[10], payload_reg[11]};
                            frame.pf      = payload_reg[12];
                        end
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == HDR_FIRST) ? PH_SECOND : PH_HUNT;
                end
            endcase
        end
    end

endmodule

### dv/tb.sv
module tb;
    import emfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [GAIN_W-1:0]      GAIN_MAX     = '1;
    localparam int                     PHASE_BYTES  = 264;
    localparam int                     HOLD_OFF     = 8;
    localparam int                     PRINT_CAP    = 40;

    typedef struct packed {
        logic                ok;
        logic [COUNT_W-1:0]  voltage;
        logic [COUNT_W-1:0]  current;
        logic [COUNT_W-1:0]  power;
        logic [COUNT_W-1:0]  energy;
        logic [BYTE_W-1:0]   pf;
        logic [SCALED_W-1:0] voltage_sc;
        logic [SCALED_W-1:0] current_sc;
        logic [SCALED_W-1:0] power_sc;
        logic [TOTAL_W-1:0]  total;
    } decoded_frame_t;

    localparam decoded_frame_t FRAME_FAILED   = '0;
    localparam decoded_frame_t FRAME_EMPTY_OK = '{ok: 1'b1, default: '0};

    // how a frame is introduced on the line
    typedef enum logic [1:0] {
        LEAD_PLAIN,   // header only
        LEAD_STRAY,   // noise and a first header byte with a wrong follower
        LEAD_DOUBLE   // repeated first header byte, which must not restart sync
    } lead_t;

    typedef struct {
        lead_t          lead;
        logic           fill_rand;
        logic [7:0]     fill;
        logic           bad_sum;
        logic           typed;
        decoded_frame_t want;
        logic           max_gains;
        int             reps;
    } frame_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      rx_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   frame_ok;
    logic [COUNT_W-1:0]     voltage_count;
    logic [COUNT_W-1:0]     current_count;
    logic [COUNT_W-1:0]     power_count;
    logic [COUNT_W-1:0]     energy_count;
    logic [BYTE_W-1:0]      power_factor_hundredths;
    logic [SCALED_W-1:0]    voltage_scaled;
    logic [SCALED_W-1:0]    current_scaled;
    logic [SCALED_W-1:0]    power_scaled;
    logic [TOTAL_W-1:0]     energy_total;

    energy_meter_frame_decoder dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the decoder
    phase_t               sync_state = PH_HUNT;
    int                   frame_pos = 0;
    logic [7:0]           field_bytes [PAYLOAD_DEPTH];
    logic [7:0]           body_total = '0;
    logic [ENERGY_WIDTH-1:0] energy_acc = '0;
    logic [GAIN_W-1:0]    gain_voltage = VOLTAGE_GAIN_RESET;
    logic [GAIN_W-1:0]    gain_current = CURRENT_GAIN_RESET;
    logic [GAIN_W-1:0]    gain_power = POWER_GAIN_RESET;

    decoded_frame_t       pending_frames [$];
    logic                 use_typed = 1'b0;
    decoded_frame_t       typed_frame = '0;
    int                   mismatch_count = 0;
    int                   frame_bytes_sent = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;

    function automatic logic [SCALED_W-1:0] apply_gain(input logic [COUNT_W-1:0] count,
                                                       input logic [GAIN_W-1:0] gain);
        logic [PRODUCT_W-1:0] prod;
        prod = PRODUCT_W'(count) * PRODUCT_W'(gain);
        return prod[GAIN_SHIFT +: SCALED_W];
    endfunction

    function automatic void track_frame_byte(input logic [7:0] b);
        decoded_frame_t res;
        logic [7:0]     neg_sum;
        case (sync_state)
            PH_SECOND:
            begin
                if (b == HDR_SECOND)
                begin
                    sync_state = PH_COLLECT;
                    frame_pos  = FIRST_PAYLOAD_POS;
                    body_total = '0;
                end
                else
                    sync_state = PH_HUNT;
            end
            PH_COLLECT:
            begin
                if (frame_pos < FRAME_LENGTH - 1)
                begin
                    if (frame_pos - FIRST_PAYLOAD_POS < PAYLOAD_DEPTH)
                        field_bytes[frame_pos - FIRST_PAYLOAD_POS] = b;
                    body_total += b;
                    frame_pos++;
                end
                else
                begin
                    sync_state = PH_HUNT;
                    frame_pos  = 0;
                    res        = '0;
                    neg_sum    = 8'd0 - body_total;
                    if (neg_sum == b)
                    begin
                        res.ok         = 1'b1;
                        res.voltage    = {field_bytes[0], field_bytes[1], field_bytes[2]};
                        res.current    = {field_bytes[3], field_bytes[4], field_bytes[5]};
                        res.power      = {field_bytes[6], field_bytes[7], field_bytes[8]};
                        res.energy     = {field_bytes[9], field_bytes[10], field_bytes[11]};
                        res.pf         = field_bytes[12];
                        res.voltage_sc = apply_gain(res.voltage, gain_voltage);
                        res.current_sc = apply_gain(res.current, gain_current);
                        res.power_sc   = apply_gain(res.power, gain_power);
                        energy_acc     = energy_acc + ENERGY_WIDTH'(res.power_sc);
                        res.total      = energy_acc[TOTAL_W-1:0];
                    end
                    body_total = '0;
                    pending_frames.push_back(use_typed ? typed_frame : res);
                end
            end
            default:
            begin
                if (b == HDR_FIRST)
                    sync_state = PH_SECOND;
                else
                    sync_state = PH_HUNT;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t %s: got %0h want %0h", $time, what, got, want);
    endtask

    always @(posedge clk)
        out_ready <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;

    always @(posedge clk)
    begin
        decoded_frame_t seen;
        decoded_frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {frame_ok, voltage_count, current_count, power_count, energy_count,
                    power_factor_hundredths, voltage_scaled, current_scaled, power_scaled,
                    energy_total};
            if (pending_frames.size() == 0)
                flag_mismatch("result with none pending", seen.ok, 0);
            else
            begin
                want = pending_frames.pop_front();
                if (seen.ok !== want.ok)
                    flag_mismatch("frame_ok", seen.ok, want.ok);
                if (seen.voltage !== want.voltage)
                    flag_mismatch("voltage_count", seen.voltage, want.voltage);
                if (seen.current !== want.current)
                    flag_mismatch("current_count", seen.current, want.current);
                if (seen.power !== want.power)
                    flag_mismatch("power_count", seen.power, want.power);
                if (seen.energy !== want.energy)
                    flag_mismatch("energy_count", seen.energy, want.energy);
                if (seen.pf !== want.pf)
                    flag_mismatch("power_factor_hundredths", seen.pf, want.pf);
                if (seen.voltage_sc !== want.voltage_sc)
                    flag_mismatch("voltage_scaled", seen.voltage_sc, want.voltage_sc);
                if (seen.current_sc !== want.current_sc)
                    flag_mismatch("current_scaled", seen.current_sc, want.current_sc);
                if (seen.power_sc !== want.power_sc)
                    flag_mismatch("power_scaled", seen.power_sc, want.power_sc);
                if (seen.total !== want.total)
                    flag_mismatch("energy_total", seen.total, want.total);
            end
        end
    end

    // called at a clock edge; returns at the edge that takes the beat
    task automatic push_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        track_frame_byte(b);
    endtask

    function automatic logic [7:0] random_body_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame(input lead_t lead, input logic fill_rand,
                              input logic [7:0] fill, input logic bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int         flip;
        sum = '0;
        if (lead == LEAD_STRAY)
        begin
            push_byte(8'h00);
            push_byte(8'hFF);
            push_byte(HDR_FIRST);
            push_byte(8'h00);
        end
        else if (lead == LEAD_DOUBLE)
        begin
            push_byte(HDR_FIRST);
            push_byte(HDR_FIRST);
        end
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        for (int k = FIRST_PAYLOAD_POS; k < FRAME_LENGTH - 1; k++)
        begin
            b = fill_rand ? random_body_byte() : fill;
            sum += b;
            push_byte(b);
        end
        b = 8'd0 - sum;
        if (bad_sum)
        begin
            flip    = $urandom_range(7);
            b[flip] = ~b[flip];
        end
        push_byte(b);
        frame_bytes_sent += FRAME_LENGTH;
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_frames.size() != 0);
    endtask

    task automatic settle();
        wait_results_drained();
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_gain(input logic [CFG_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_VOLTAGE_GAIN: gain_voltage = val;
            CFG_CURRENT_GAIN: gain_current = val;
            CFG_POWER_GAIN:   gain_power   = val;
            default:          ;
        endcase
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] gv, input logic [GAIN_W-1:0] gi,
                              input logic [GAIN_W-1:0] gp);
        write_gain(CFG_VOLTAGE_GAIN, gv);
        write_gain(CFG_CURRENT_GAIN, gi);
        write_gain(CFG_POWER_GAIN, gp);
    endtask

    task automatic random_traffic();
        int         pick;
        int         n;
        int         start_bytes;
        logic [7:0] b;
        lead_t      lead;
        start_bytes = frame_bytes_sent;
        while (frame_bytes_sent - start_bytes < PHASE_BYTES)
        begin
            pick = $urandom_range(99);
            n    = $urandom_range(9);
            lead = (n == 0) ? LEAD_STRAY : (n == 1) ? LEAD_DOUBLE : LEAD_PLAIN;
            if (pick < 70)
                send_frame(lead, 1'b1, 8'h00, 1'b0);
            else if (pick < 82)
                send_frame(lead, 1'b1, 8'h00, 1'b1);
            else if (pick < 91)
            begin
                // broken header
                push_byte(HDR_FIRST);
                do b = 8'($urandom_range(255)); while (b == HDR_SECOND);
                push_byte(b);
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                    push_byte($urandom_range(3) == 0 ? HDR_FIRST : 8'($urandom_range(255)));
            end
            if ($urandom_range(15) == 0)
                wait_results_drained();
        end
    endtask

    initial
    begin
        frame_row_t rows [$];
        rows.push_back('{LEAD_PLAIN,  1'b0, 8'h00, 1'b0, 1'b1, FRAME_EMPTY_OK, 1'b0, 1});
        rows.push_back('{LEAD_PLAIN,  1'b0, 8'hFF, 1'b0, 1'b0, FRAME_FAILED,   1'b0, 1});
        rows.push_back('{LEAD_PLAIN,  1'b0, 8'h00, 1'b1, 1'b1, FRAME_FAILED,   1'b0, 1});
        rows.push_back('{LEAD_PLAIN,  1'b0, 8'hFF, 1'b1, 1'b1, FRAME_FAILED,   1'b0, 1});
        rows.push_back('{LEAD_STRAY,  1'b1, 8'h00, 1'b0, 1'b0, FRAME_FAILED,   1'b0, 1});
        rows.push_back('{LEAD_DOUBLE, 1'b1, 8'h00, 1'b0, 1'b0, FRAME_FAILED,   1'b0, 1});
        rows.push_back('{LEAD_PLAIN,  1'b1, 8'h00, 1'b1, 1'b1, FRAME_FAILED,   1'b0, 1});
        rows.push_back('{LEAD_PLAIN,  1'b0, HDR_FIRST,  1'b0, 1'b0, FRAME_FAILED, 1'b0, 1});
        rows.push_back('{LEAD_PLAIN,  1'b0, HDR_SECOND, 1'b0, 1'b0, FRAME_FAILED, 1'b0, 1});
        // full-scale counts at full gain, widest products
        rows.push_back('{LEAD_PLAIN,  1'b0, 8'hFF, 1'b0, 1'b0, FRAME_FAILED,   1'b1, 1});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            if (rows[r].max_gains)
            begin
                settle();
                load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
            end
            use_typed   = rows[r].typed;
            typed_frame = rows[r].want;
            repeat (rows[r].reps)
                send_frame(rows[r].lead, rows[r].fill_rand, rows[r].fill, rows[r].bad_sum);
        end
        use_typed = 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    load_gains(GAIN_W'($urandom_range(GAIN_MAX)),
                               GAIN_W'($urandom_range(GAIN_MAX)),
                               GAIN_W'($urandom_range(GAIN_MAX)));
                    write_gain(CFG_UNMAPPED, GAIN_W'($urandom_range(GAIN_MAX)));
                end
                1:
                begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                    load_gains('0, '0, '0);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                    load_gains(VOLTAGE_GAIN_RESET, CURRENT_GAIN_RESET, POWER_GAIN_RESET);
                end
                default:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                    write_gain(CFG_UNMAPPED, GAIN_MAX);
                    load_gains(GAIN_W'($urandom_range(GAIN_MAX)),
                               GAIN_W'($urandom_range(GAIN_MAX)),
                               GAIN_W'($urandom_range(GAIN_MAX)));
                end
            endcase
            random_traffic();
        end

        settle();
        if (mismatch_count == 0)
            $display("energy_meter_frame_decoder: match");
        else
            $display("energy_meter_frame_decoder: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("energy_meter_frame_decoder: mismatch");
        $finish;
    end

endmodule
